// ----- rtl/core/lruhc_pkg.sv -----
// ----------------------------------------------------------------------------
// lruhc_pkg
// Shared types and codes for the reference-counted LRU handle cache: request
// and response payloads, command codes, status codes, controller links.
// ----------------------------------------------------------------------------
package lruhc_pkg;

  // request commands
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // response status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FILLED   = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_UNCACHED = 3'd3;
  localparam logic [2:0] ST_REG_FAIL = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;
  localparam logic [2:0] ST_FREED    = 3'd6;
  localparam logic [2:0] ST_NULL     = 3'd7;

  // input request payload
  typedef struct packed {
    logic        command;
    logic [63:0] buffer_addr;
    logic [31:0] buffer_len;
    logic        access_write;
    logic        register_ok;
    logic [15:0] new_handle;
    logic [15:0] release_handle;
  } req_t;

  // result payload
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic        free_valid;
    logic [15:0] freed_handle;
    logic [63:0] hit_total;
    logic [63:0] miss_total;
    logic [63:0] evict_total;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, restart the slot scan
    logic issue;   // read the next slot
    logic commit;  // apply the update and load the result register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // the slot read this cycle is the last one
  } ctl_sts_t;

endpackage

// ----- rtl/core/lruhc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lruhc_ctrl
// Sequencer for the handle cache: takes a request, walks the slot scan,
// commits the update once the result register is free.
// ----------------------------------------------------------------------------
module lruhc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lruhc_pkg::ctl_sts_t sts,
  output lruhc_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/lruhc_dp.sv -----
// ----------------------------------------------------------------------------
// lruhc_dp
// Datapath of the handle cache: slot memories, one-slot-per-cycle scan for
// match, first empty slot and LRU victim, entry update, running totals and
// the result register.
// ----------------------------------------------------------------------------
module lruhc_dp #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 16,
  parameter int REF_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lruhc_pkg::req_t     in_data,
  input  lruhc_pkg::ctl_cmd_t cmd,
  output lruhc_pkg::ctl_sts_t sts,
  output lruhc_pkg::rsp_t     out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int HW = HANDLE_BITS;
  localparam int RW = REF_BITS;

  // captured request
  lruhc_pkg::req_t req_r;
  logic [HW-1:0]   nh;
  logic [HW-1:0]   rh;

  // slot memories
  logic [63:0]   mem_addr   [SLOTS];
  logic [31:0]   mem_len    [SLOTS];
  logic          mem_dir    [SLOTS];
  logic [HW-1:0] mem_handle [SLOTS];
  logic [RW-1:0] mem_refs   [SLOTS];
  logic [63:0]   mem_stamp  [SLOTS];
  logic [SLOTS-1:0] valid_r;

  // registered read data
  logic [63:0]   rd_addr_r;
  logic [31:0]   rd_len_r;
  logic          rd_dir_r;
  logic [HW-1:0] rd_handle_r;
  logic [RW-1:0] rd_refs_r;
  logic [63:0]   rd_stamp_r;
  logic          rd_vld_r;

  // scan position
  logic [IW-1:0] idx_r;
  logic          look_r;
  logic [IW-1:0] look_idx_r;

  // scan findings
  logic          hit_found_r;
  logic [IW-1:0] hit_idx_r;
  logic [RW-1:0] hit_refs_r;
  logic [HW-1:0] hit_handle_r;
  logic          empty_found_r;
  logic [IW-1:0] empty_idx_r;
  logic          vic_found_r;
  logic [IW-1:0] vic_idx_r;
  logic [63:0]   vic_stamp_r;
  logic [HW-1:0] vic_handle_r;

  // totals
  logic [63:0] lru_r, lru_nxt;
  logic [63:0] hits_r, hits_nxt;
  logic [63:0] misses_r, misses_nxt;
  logic [63:0] evict_r, evict_nxt;

  // update controls
  logic          wr_refs_en;
  logic          wr_stamp_en;
  logic          wr_key_en;
  logic [IW-1:0] wr_idx;
  logic [RW-1:0] wr_refs;
  logic          key_match;
  logic          live;

  lruhc_pkg::rsp_t out_r, out_nxt;

  assign nh = HW'(req_r.new_handle);
  assign rh = HW'(req_r.release_handle);
  assign sts.scan_last = (idx_r == IW'(SLOTS - 1));
  assign out_data = out_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  // scan counter and read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      look_r <= 1'b0;
    end else begin
      look_r <= cmd.issue;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.issue) begin
        idx_r <= sts.scan_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    look_idx_r <= idx_r;
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    rd_addr_r   <= mem_addr[idx_r];
    rd_len_r    <= mem_len[idx_r];
    rd_dir_r    <= mem_dir[idx_r];
    rd_handle_r <= mem_handle[idx_r];
    rd_refs_r   <= mem_refs[idx_r];
    rd_stamp_r  <= mem_stamp[idx_r];
    if (cmd.commit && wr_refs_en) begin
      mem_refs[wr_idx] <= wr_refs;
    end
    if (cmd.commit && wr_stamp_en) begin
      mem_stamp[wr_idx] <= lru_nxt;
    end
    if (cmd.commit && wr_key_en) begin
      mem_addr[wr_idx]   <= req_r.buffer_addr;
      mem_len[wr_idx]    <= req_r.buffer_len;
      mem_dir[wr_idx]    <= req_r.access_write;
      mem_handle[wr_idx] <= nh;
    end
  end

  // slot occupied flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[idx_r];
      if (cmd.commit && wr_key_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // compare stage
  assign live = rd_vld_r;
  assign key_match = live && (rd_addr_r == req_r.buffer_addr) &&
                     (rd_len_r == req_r.buffer_len) && (rd_dir_r == req_r.access_write);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (look_r) begin
      // first matching slot, by key on acquire or by handle on release
      if (!hit_found_r && ((req_r.command == lruhc_pkg::CMD_ACQUIRE) ? key_match :
                           (live && (rd_handle_r == rh)))) begin
        hit_found_r  <= 1'b1;
        hit_idx_r    <= look_idx_r;
        hit_refs_r   <= rd_refs_r;
        hit_handle_r <= rd_handle_r;
      end
      // first empty slot
      if (!live && !empty_found_r) begin
        empty_found_r <= 1'b1;
        empty_idx_r   <= look_idx_r;
      end
      // oldest unreferenced entry, lowest slot on ties
      if (live && (rd_refs_r == '0) && (!vic_found_r || (rd_stamp_r < vic_stamp_r))) begin
        vic_found_r  <= 1'b1;
        vic_idx_r    <= look_idx_r;
        vic_stamp_r  <= rd_stamp_r;
        vic_handle_r <= rd_handle_r;
      end
    end
  end

  // update decision and result
  always_comb begin
    wr_refs_en  = 1'b0;
    wr_stamp_en = 1'b0;
    wr_key_en   = 1'b0;
    wr_idx      = hit_idx_r;
    wr_refs     = hit_refs_r;
    lru_nxt     = lru_r;
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    evict_nxt   = evict_r;
    out_nxt.status       = lruhc_pkg::ST_NULL;
    out_nxt.out_handle   = '0;
    out_nxt.free_valid   = 1'b0;
    out_nxt.freed_handle = '0;
    if (req_r.command == lruhc_pkg::CMD_ACQUIRE) begin
      if (hit_found_r) begin
        wr_refs_en  = 1'b1;
        wr_stamp_en = 1'b1;
        wr_refs     = (hit_refs_r == '1) ? hit_refs_r : hit_refs_r + 1'b1;
        lru_nxt     = lru_r + 64'd1;
        hits_nxt    = hits_r + 64'd1;
        out_nxt.status     = lruhc_pkg::ST_HIT;
        out_nxt.out_handle = 16'(hit_handle_r);
      end else begin
        misses_nxt = misses_r + 64'd1;
        if (!req_r.register_ok || (nh == '0)) begin
          out_nxt.status = lruhc_pkg::ST_REG_FAIL;
        end else if (empty_found_r || vic_found_r) begin
          wr_refs_en  = 1'b1;
          wr_stamp_en = 1'b1;
          wr_key_en   = 1'b1;
          wr_refs     = RW'(1);
          lru_nxt     = lru_r + 64'd1;
          out_nxt.out_handle = 16'(nh);
          if (empty_found_r) begin
            wr_idx         = empty_idx_r;
            out_nxt.status = lruhc_pkg::ST_FILLED;
          end else begin
            wr_idx               = vic_idx_r;
            evict_nxt            = evict_r + 64'd1;
            out_nxt.status       = lruhc_pkg::ST_EVICTED;
            out_nxt.free_valid   = 1'b1;
            out_nxt.freed_handle = 16'(vic_handle_r);
          end
        end else begin
          out_nxt.status     = lruhc_pkg::ST_UNCACHED;
          out_nxt.out_handle = 16'(nh);
        end
      end
    end else if (rh != '0) begin
      if (hit_found_r) begin
        wr_refs_en     = 1'b1;
        wr_refs        = (hit_refs_r == '0) ? hit_refs_r : hit_refs_r - 1'b1;
        out_nxt.status = lruhc_pkg::ST_RELEASED;
      end else begin
        out_nxt.status       = lruhc_pkg::ST_FREED;
        out_nxt.free_valid   = 1'b1;
        out_nxt.freed_handle = 16'(rh);
      end
    end
    out_nxt.hit_total   = hits_nxt;
    out_nxt.miss_total  = misses_nxt;
    out_nxt.evict_total = evict_nxt;
  end

  // totals and lru clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lru_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evict_r  <= '0;
    end else if (cmd.commit) begin
      lru_r    <= lru_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evict_r  <= evict_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- rtl/core/refcounted_lru_handle_cache.sv -----
// ----------------------------------------------------------------------------
// refcounted_lru_handle_cache
// Fully associative cache of registered buffer handles with reference
// counts and LRU replacement of unreferenced entries.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  in       | in_valid / in_ready    | in_data  (lruhc_pkg::req_t)
//  out      | out_valid / out_ready  | out_data (lruhc_pkg::rsp_t)
//
// Each request is captured, then all SLOTS slots are read one slot per
// cycle through the single slot memory read port, the registered read is
// drained, and then the update is committed and the result register loaded.
// The result register lets a new request be taken while a result waits.
// The commit waits while the result register is still full.
// Reset marks every slot empty and clears the totals and the lru clock.
// ----------------------------------------------------------------------------
module refcounted_lru_handle_cache #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 16,
  parameter int REF_BITS    = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lruhc_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lruhc_pkg::rsp_t out_data
);

  lruhc_pkg::ctl_cmd_t cmd;
  lruhc_pkg::ctl_sts_t sts;

  // sequencer
  lruhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot store and update logic
  lruhc_dp #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS),
    .REF_BITS    (REF_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // busy right after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while a scan was starting");

  // a result only appears after a commit
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

  // commit never overwrites a waiting result
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over a pending result");

  // a freed handle goes with eviction or an unknown release
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.free_valid ==
      ((out_data.status == lruhc_pkg::ST_EVICTED) || (out_data.status == lruhc_pkg::ST_FREED))))
    else $error("free flag disagrees with status");

endmodule

// ----- tb/tb_refcounted_lru_handle_cache.sv -----
// ----------------------------------------------------------------------------
// tb_refcounted_lru_handle_cache
// Self-checking bench for the reference-counted LRU handle cache. A short
// table of requests covers null and unknown releases, failed registrations,
// fills, hits, duplicate handles and counts that cannot drop below zero.
// Random requests follow. They run in phases that fill the cache until every
// entry is pinned, churn it, and release it again, which drives uncached
// grants and LRU evictions. The shadow cache predicts every response that
// the table does not write out. Each response is checked field by field in
// order, while the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_refcounted_lru_handle_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 64;
  localparam int POOL_KEYS  = 96;
  localparam int DIR_ROWS   = 17;
  localparam int RAND_ITEMS = 1533;

  typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_RELEASE} mix_t;

  // one directed row: request, whether the response is written out, response
  typedef struct packed {
    lruhc_pkg::req_t req;
    logic            known;
    lruhc_pkg::rsp_t rsp;
  } row_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  lruhc_pkg::req_t in_data   = '0;
  logic            out_ready = 1'b0;
  logic            in_ready;
  logic            out_valid;
  lruhc_pkg::rsp_t out_data;

  // shadow copy of the cache
  logic [15:0] ent_handle [SLOTS];
  logic [63:0] ent_addr   [SLOTS];
  logic [31:0] ent_len    [SLOTS];
  logic        ent_dir    [SLOTS];
  logic [15:0] ent_refs   [SLOTS];
  logic [63:0] ent_stamp  [SLOTS];
  logic [63:0] use_clock;
  logic [63:0] hit_count;
  logic [63:0] miss_count;
  logic [63:0] evict_count;

  // lookup keys reused by the random requests
  logic [63:0] pool_addr [POOL_KEYS];
  logic [31:0] pool_len  [POOL_KEYS];
  logic        pool_dir  [POOL_KEYS];

  lruhc_pkg::rsp_t due_rsp [$];
  lruhc_pkg::rsp_t want_rsp;
  row_t            steer_rows [DIR_ROWS];
  logic [15:0]     last_uncached = '0;
  int              burst_left    = 0;
  int              ready_left    = 0;
  int              fail_count    = 0;

  refcounted_lru_handle_cache #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (16),
    .REF_BITS    (16)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("refcounted_lru_handle_cache regression: fail");
    $finish;
  end

  function automatic lruhc_pkg::req_t acq_req(input logic [63:0] addr,
                                              input logic [31:0] len,
                                              input logic wr, input logic ok,
                                              input logic [15:0] nh);
    lruhc_pkg::req_t r;
    r = '0;
    r.command      = lruhc_pkg::CMD_ACQUIRE;
    r.buffer_addr  = addr;
    r.buffer_len   = len;
    r.access_write = wr;
    r.register_ok  = ok;
    r.new_handle   = nh;
    return r;
  endfunction

  function automatic lruhc_pkg::req_t rel_req(input logic [15:0] h);
    lruhc_pkg::req_t r;
    r = '0;
    r.command        = lruhc_pkg::CMD_RELEASE;
    r.release_handle = h;
    return r;
  endfunction

  function automatic lruhc_pkg::rsp_t rsp_of(input logic [2:0] st, input logic [15:0] oh,
                                             input logic fv, input logic [15:0] fh,
                                             input logic [63:0] h, input logic [63:0] m,
                                             input logic [63:0] e);
    return lruhc_pkg::rsp_t'{st, oh, fv, fh, h, m, e};
  endfunction

  // apply one request to the shadow cache, return the response it yields
  function automatic lruhc_pkg::rsp_t cache_apply(input lruhc_pkg::req_t r);
    lruhc_pkg::rsp_t o;
    int              i, hit_at, empty_at, victim_at, found_at, s;
    o         = '0;
    hit_at    = -1;
    empty_at  = -1;
    victim_at = -1;
    found_at  = -1;
    if (r.command == lruhc_pkg::CMD_ACQUIRE) begin
      // match, first empty slot and oldest unpinned entry in one pass
      for (i = 0; i < SLOTS; i++) begin
        if (ent_handle[i] != '0 && ent_addr[i] == r.buffer_addr &&
            ent_len[i] == r.buffer_len && ent_dir[i] == r.access_write) begin
          hit_at = i;
          break;
        end
        if (ent_handle[i] == '0) begin
          if (empty_at < 0) empty_at = i;
        end else if (ent_refs[i] == '0 &&
                     (victim_at < 0 || ent_stamp[i] < ent_stamp[victim_at])) begin
          victim_at = i;
        end
      end
      if (hit_at >= 0) begin
        if (ent_refs[hit_at] != '1) ent_refs[hit_at] = ent_refs[hit_at] + 16'd1;
        use_clock         = use_clock + 64'd1;
        ent_stamp[hit_at] = use_clock;
        hit_count         = hit_count + 64'd1;
        o.status          = lruhc_pkg::ST_HIT;
        o.out_handle      = ent_handle[hit_at];
      end else begin
        miss_count = miss_count + 64'd1;
        if (!r.register_ok || r.new_handle == '0) begin
          o.status = lruhc_pkg::ST_REG_FAIL;
        end else begin
          s = (empty_at >= 0) ? empty_at : victim_at;
          if (s < 0) begin
            // every entry pinned
            o.status     = lruhc_pkg::ST_UNCACHED;
            o.out_handle = r.new_handle;
          end else begin
            if (ent_handle[s] != '0) begin
              o.status       = lruhc_pkg::ST_EVICTED;
              o.free_valid   = 1'b1;
              o.freed_handle = ent_handle[s];
              evict_count    = evict_count + 64'd1;
            end else begin
              o.status = lruhc_pkg::ST_FILLED;
            end
            ent_addr[s]   = r.buffer_addr;
            ent_len[s]    = r.buffer_len;
            ent_dir[s]    = r.access_write;
            ent_handle[s] = r.new_handle;
            ent_refs[s]   = 16'd1;
            use_clock     = use_clock + 64'd1;
            ent_stamp[s]  = use_clock;
            o.out_handle  = r.new_handle;
          end
        end
      end
    end else if (r.release_handle == '0) begin
      o.status = lruhc_pkg::ST_NULL;
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (ent_handle[i] == r.release_handle) begin
          found_at = i;
          break;
        end
      end
      if (found_at >= 0) begin
        if (ent_refs[found_at] != '0) ent_refs[found_at] = ent_refs[found_at] - 16'd1;
        o.status = lruhc_pkg::ST_RELEASED;
      end else begin
        o.status       = lruhc_pkg::ST_FREED;
        o.free_valid   = 1'b1;
        o.freed_handle = r.release_handle;
      end
    end
    o.hit_total   = hit_count;
    o.miss_total  = miss_count;
    o.evict_total = evict_count;
    return o;
  endfunction

  // a handle currently held by some entry, or a random one if none is found
  function automatic logic [15:0] live_handle();
    int n, k;
    for (n = 0; n < 8; n++) begin
      k = $urandom_range(0, SLOTS - 1);
      if (ent_handle[k] != '0) return ent_handle[k];
    end
    return 16'($urandom_range(1, 16'hFFFF));
  endfunction

  function automatic lruhc_pkg::req_t random_request(input mix_t mix);
    lruhc_pkg::req_t r;
    int              pick, k, acq_pct;
    // every field random first so all bits move, then shape
    r.buffer_addr    = {$urandom, $urandom};
    r.buffer_len     = $urandom;
    r.access_write   = 1'($urandom_range(0, 1));
    r.register_ok    = ($urandom_range(0, 99) < 92);
    r.new_handle     = 16'($urandom_range(1, 16'hFFFF));
    r.release_handle = 16'($urandom);
    acq_pct = (mix == MIX_FILL) ? 90 : (mix == MIX_CHURN) ? 60 : 25;
    if ($urandom_range(0, 99) < acq_pct) begin
      r.command = lruhc_pkg::CMD_ACQUIRE;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_KEYS - 1);
      if (pick < 92) begin
        r.buffer_addr  = pool_addr[k];
        r.buffer_len   = pool_len[k];
        r.access_write = pool_dir[k];
      end
      // near miss: one key bit off
      if (pick >= 85 && pick < 89) begin
        r.buffer_addr = r.buffer_addr ^ (64'd1 << $urandom_range(0, 63));
      end else if (pick >= 89 && pick < 92) begin
        r.buffer_len = r.buffer_len ^ (32'd1 << $urandom_range(0, 31));
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) r.new_handle = '0;
      else if (pick < 9) r.new_handle = live_handle();
      else if (pick < 12) r.new_handle = '1;
    end else begin
      r.command = lruhc_pkg::CMD_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 75) r.release_handle = live_handle();
      else if (pick < 83) r.release_handle = '0;
      else if (pick < 88) r.release_handle = last_uncached;
    end
    return r;
  endfunction

  // send one request in bursts with random gaps, predict on acceptance
  task automatic issue_request(input lruhc_pkg::req_t r, input logic known,
                               input lruhc_pkg::rsp_t fixed_rsp);
    lruhc_pkg::rsp_t calc;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(9, 90)) @(negedge clk);
        else repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    calc = cache_apply(r);
    if (calc.status == lruhc_pkg::ST_UNCACHED) last_uncached = calc.out_handle;
    due_rsp.push_back(known ? fixed_rsp : calc);
    burst_left--;
    @(negedge clk);
  endtask

  // receiver stall pattern: long ready runs, short and long stalls, flicker
  always @(negedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 6))
        0: begin
          out_ready <= 1'b0;
          ready_left = $urandom_range(20, 100);
        end
        1, 2: begin
          out_ready <= 1'b0;
          ready_left = $urandom_range(1, 6);
        end
        3: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_left = 0;
        end
        default: begin
          out_ready <= 1'b1;
          ready_left = $urandom_range(1, 300);
        end
      endcase
    end else begin
      ready_left--;
    end
  end

  // response check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_rsp.size() == 0) begin
        $error("response with none outstanding: status %0d handle %h",
               out_data.status, out_data.out_handle);
        fail_count++;
      end else begin
        want_rsp = due_rsp.pop_front();
        if (out_data.status !== want_rsp.status) begin
          $error("status: expected %0d, actual %0d", want_rsp.status, out_data.status);
          fail_count++;
        end
        if (out_data.out_handle !== want_rsp.out_handle) begin
          $error("out_handle: expected %h, actual %h",
                 want_rsp.out_handle, out_data.out_handle);
          fail_count++;
        end
        if (out_data.free_valid !== want_rsp.free_valid) begin
          $error("free_valid: expected %b, actual %b",
                 want_rsp.free_valid, out_data.free_valid);
          fail_count++;
        end
        if (out_data.freed_handle !== want_rsp.freed_handle) begin
          $error("freed_handle: expected %h, actual %h",
                 want_rsp.freed_handle, out_data.freed_handle);
          fail_count++;
        end
        if (out_data.hit_total !== want_rsp.hit_total) begin
          $error("hit_total: expected %0d, actual %0d",
                 want_rsp.hit_total, out_data.hit_total);
          fail_count++;
        end
        if (out_data.miss_total !== want_rsp.miss_total) begin
          $error("miss_total: expected %0d, actual %0d",
                 want_rsp.miss_total, out_data.miss_total);
          fail_count++;
        end
        if (out_data.evict_total !== want_rsp.evict_total) begin
          $error("evict_total: expected %0d, actual %0d",
                 want_rsp.evict_total, out_data.evict_total);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int   i, ph, k, phase_len, sent;
    mix_t mix;

    // empty shadow cache, cleared totals
    for (i = 0; i < SLOTS; i++) begin
      ent_handle[i] = '0;
      ent_refs[i]   = '0;
      ent_stamp[i]  = '0;
    end
    use_clock   = '0;
    hit_count   = '0;
    miss_count  = '0;
    evict_count = '0;

    // key pool, with neighbors that share the address but differ in length or direction
    for (i = 0; i < POOL_KEYS; i++) begin
      pool_addr[i] = {$urandom, $urandom};
      pool_len[i]  = $urandom;
      pool_dir[i]  = 1'($urandom_range(0, 1));
      if (i % 8 == 1) begin
        pool_addr[i] = pool_addr[i-1];
        pool_len[i]  = pool_len[i-1];
        pool_dir[i]  = !pool_dir[i-1];
      end else if (i % 8 == 2) begin
        pool_addr[i] = pool_addr[i-2];
        pool_dir[i]  = pool_dir[i-2];
      end
    end

    // directed rows: key a is all ones, a2 is a read-only twin, b is all zeros
    steer_rows[0]  = '{rel_req(16'h0000), 1'b1,
                       rsp_of(lruhc_pkg::ST_NULL, 0, 0, 0, 0, 0, 0)};
    steer_rows[1]  = '{rel_req(16'hFFFF), 1'b1,
                       rsp_of(lruhc_pkg::ST_FREED, 0, 1'b1, 16'hFFFF, 0, 0, 0)};
    steer_rows[2]  = '{acq_req('1, '1, 1'b1, 1'b0, 16'h0005), 1'b1,
                       rsp_of(lruhc_pkg::ST_REG_FAIL, 0, 0, 0, 0, 1, 0)};
    steer_rows[3]  = '{acq_req('1, '1, 1'b1, 1'b1, 16'h0000), 1'b1,
                       rsp_of(lruhc_pkg::ST_REG_FAIL, 0, 0, 0, 0, 2, 0)};
    steer_rows[4]  = '{acq_req('1, '1, 1'b1, 1'b1, 16'hFFFF), 1'b1,
                       rsp_of(lruhc_pkg::ST_FILLED, 16'hFFFF, 0, 0, 0, 3, 0)};
    steer_rows[5]  = '{acq_req('1, '1, 1'b1, 1'b0, 16'h0000), 1'b1,
                       rsp_of(lruhc_pkg::ST_HIT, 16'hFFFF, 0, 0, 1, 3, 0)};
    steer_rows[6]  = '{acq_req('1, '1, 1'b0, 1'b1, 16'h0001), 1'b1,
                       rsp_of(lruhc_pkg::ST_FILLED, 16'h0001, 0, 0, 1, 4, 0)};
    // same handle as a2, lowest slot wins on release
    steer_rows[7]  = '{acq_req('0, '0, 1'b0, 1'b1, 16'h0001), 1'b1,
                       rsp_of(lruhc_pkg::ST_FILLED, 16'h0001, 0, 0, 1, 5, 0)};
    steer_rows[8]  = '{rel_req(16'h0001), 1'b1,
                       rsp_of(lruhc_pkg::ST_RELEASED, 0, 0, 0, 1, 5, 0)};
    // count already zero, stays there
    steer_rows[9]  = '{rel_req(16'h0001), 1'b1,
                       rsp_of(lruhc_pkg::ST_RELEASED, 0, 0, 0, 1, 5, 0)};
    steer_rows[10] = '{rel_req(16'hFFFF), 1'b1,
                       rsp_of(lruhc_pkg::ST_RELEASED, 0, 0, 0, 1, 5, 0)};
    steer_rows[11] = '{acq_req('0, '0, 1'b0, 1'b0, 16'h0000), 1'b1,
                       rsp_of(lruhc_pkg::ST_HIT, 16'h0001, 0, 0, 2, 5, 0)};
    steer_rows[12] = '{acq_req('1, '0, 1'b1, 1'b1, 16'h8000), 1'b0, '0};
    steer_rows[13] = '{acq_req(64'h8000_0000_0000_0001, 32'h8000_0000, 1'b0, 1'b1,
                               16'h7FFF), 1'b0, '0};
    steer_rows[14] = '{rel_req(16'h8000), 1'b0, '0};
    steer_rows[15] = '{acq_req('1, '1, 1'b1, 1'b1, 16'h1234), 1'b0, '0};
    steer_rows[16] = '{rel_req(16'h5555), 1'b0, '0};

    // reset
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      issue_request(steer_rows[i].req, steer_rows[i].known, steer_rows[i].rsp);
    end

    // random phases: fill until pinned, churn, release
    sent = 0;
    for (ph = 0; sent < RAND_ITEMS; ph++) begin
      mix       = mix_t'(ph % 3);
      phase_len = $urandom_range(100, 250);
      for (k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
        issue_request(random_request(mix), 1'b0, '0);
        sent++;
      end
      // after every odd phase, hold off until the block has drained
      if (ph % 2 == 1) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (due_rsp.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (due_rsp.size() != 0);
    repeat (SLOTS + 16) @(negedge clk);
    if (fail_count == 0) begin
      $display("refcounted_lru_handle_cache regression: pass");
    end else begin
      $display("refcounted_lru_handle_cache regression: fail");
    end
    $finish;
  end

endmodule
